>>> rtl/bls_pkg.sv
// Shared types and constants for the thick-line Bresenham stepper.
// No dependencies; imported by bresenham_line_stepper_thick_top, bls_checker and tb.
package bls_pkg;

    // coordinate width of the endpoints and of the stepper position
    localparam int COORD_BITS = 12;
    // emitted pixel coordinates carry one extra bit for the widening offset
    localparam int PIX_W      = COORD_BITS + 1;
    localparam int DELTA_W    = COORD_BITS + 1;
    localparam int ERR_W      = COORD_BITS + 2;

    // configuration registers
    localparam int CFG_W      = 11;
    localparam int CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'd1;
    localparam logic [CFG_W-1:0] SCREEN_WIDTH_RST  = 11'd640;
    localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RST = 11'd350;

    // stream payload widths, padded to whole bytes
    localparam int IN_FIELDS_W  = 4 * COORD_BITS + 5;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 2 * PIX_W + 4;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_USER_W   = 2;

    // width used for the on-screen compare
    localparam int CMP_W = (PIX_W > CFG_W + 1) ? PIX_W : CFG_W + 1;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        WIDEN_NONE = 2'd0,
        WIDEN_Y    = 2'd1,
        WIDEN_X    = 2'd2
    } t_widen;

endpackage

>>> rtl/bresenham_line_stepper_thick_top.sv
// Bresenham line stepper with optional three-pixel-wide output, top level.
// Latency: a step beat's first pixel is presented the cycle after it is accepted.
// Throughput: one load beat per cycle and one step beat per cycle in thin mode, while the
// output is not stalled; in thick mode a step beat is taken only as the previous step's last
// pixel drains, set by the single pixel output register. Reset (synchronous, active low):
// no active line, screen size 640 x 350. Depends on bls_pkg.
module bresenham_line_stepper_thick_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [bls_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bls_pkg::CFG_W-1:0]       i_cfg_data,
    // input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // x_start, y_start, x_end, y_end, pen_color, thick, zero pad
    input  logic [bls_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // opcode
    input  logic                            s_axis_tuser,
    // output stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // pixel_x, pixel_y, pixel_color, zero pad
    output logic [bls_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // on_screen, line_done
    output logic [bls_pkg::OUT_USER_W-1:0]  m_axis_tuser,
    // last_of_step
    output logic                            m_axis_tlast
);
    import bls_pkg::*;

    localparam int CB = COORD_BITS;

    // configuration
    logic [CFG_W-1:0] r_scr_w, r_scr_h;

    // line state
    logic                 r_active;
    logic [CB-1:0]        r_cur_x, r_cur_y, r_goal_x, r_goal_y;
    logic [DELTA_W-1:0]   r_dx, r_dy;
    logic                 r_dir_x_neg, r_dir_y_neg;
    logic [ERR_W-1:0]     r_err;
    logic [3:0]           r_color;
    t_widen               r_widen;

    // pixel output register
    logic                 r_ovalid;
    logic [CB-1:0]        r_ox, r_oy;
    logic [3:0]           r_ocolor;
    t_widen               r_owiden;
    logic                 r_odone;
    logic [1:0]           r_beat;

    // input field unpacking
    t_opcode              in_op;
    logic [CB-1:0]        in_x0, in_y0, in_x1, in_y1;
    logic [3:0]           in_color;
    logic                 in_thick;

    assign in_op    = t_opcode'(s_axis_tuser);
    assign in_x0    = s_axis_tdata[CB-1:0];
    assign in_y0    = s_axis_tdata[2*CB-1:CB];
    assign in_x1    = s_axis_tdata[3*CB-1:2*CB];
    assign in_y1    = s_axis_tdata[4*CB-1:3*CB];
    assign in_color = s_axis_tdata[4*CB+3:4*CB];
    assign in_thick = s_axis_tdata[4*CB+4];

    // handshake: take a new beat when the pixel register is empty or drains now
    logic out_fire, out_last, in_fire, step_go, load_go;

    assign out_last      = (r_owiden == WIDEN_NONE) || (r_beat == 2'd2);
    assign out_fire      = r_ovalid && m_axis_tready;
    assign s_axis_tready = !r_ovalid || (m_axis_tready && out_last);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign load_go       = in_fire && (in_op == OP_LOAD);
    assign step_go       = in_fire && (in_op == OP_STEP) && r_active;

    // load setup: deltas, directions, initial error, widening mode
    logic signed [DELTA_W-1:0] ld_diff_x, ld_diff_y;
    logic                      ld_gt_x, ld_gt_y;
    logic [DELTA_W-1:0]        ld_dx, ld_dy;
    logic [ERR_W-1:0]          ld_err;
    t_widen                    ld_widen;

    always_comb begin
        ld_gt_x   = $signed(in_x1) > $signed(in_x0);
        ld_gt_y   = $signed(in_y1) > $signed(in_y0);
        ld_diff_x = $signed({in_x1[CB-1], in_x1}) - $signed({in_x0[CB-1], in_x0});
        ld_diff_y = $signed({in_y1[CB-1], in_y1}) - $signed({in_y0[CB-1], in_y0});
        ld_dx     = ld_gt_x ? DELTA_W'(ld_diff_x) : DELTA_W'(-ld_diff_x);
        ld_dy     = ld_gt_y ? DELTA_W'(ld_diff_y) : DELTA_W'(-ld_diff_y);
        if (ld_dx > ld_dy) begin
            ld_err = {2'b00, ld_dx[DELTA_W-1:1]};
        end else begin
            ld_err = -{2'b00, ld_dy[DELTA_W-1:1]};
        end
        if (!in_thick) begin
            ld_widen = WIDEN_NONE;
        end else if (ld_dx >= ld_dy) begin
            ld_widen = WIDEN_Y;
        end else begin
            ld_widen = WIDEN_X;
        end
    end

    // one Bresenham step from the current state
    logic                    st_done, st_mv_x, st_mv_y;
    logic signed [ERR_W:0]   st_e, st_dx, st_dy, st_sum;
    logic [CB-1:0]           n_cur_x, n_cur_y;
    logic [ERR_W-1:0]        n_err;

    always_comb begin
        st_done = (r_cur_x == r_goal_x) && (r_cur_y == r_goal_y);
        st_e    = $signed({r_err[ERR_W-1], r_err});
        st_dx   = $signed({2'b00, r_dx});
        st_dy   = $signed({2'b00, r_dy});
        st_mv_x = st_e > -st_dx;
        st_mv_y = st_e < st_dy;
        st_sum  = st_e - (st_mv_x ? st_dy : '0) + (st_mv_y ? st_dx : '0);
        n_err   = st_sum[ERR_W-1:0];
        n_cur_x = r_cur_x;
        n_cur_y = r_cur_y;
        if (st_mv_x) begin
            n_cur_x = r_dir_x_neg ? r_cur_x - CB'(1) : r_cur_x + CB'(1);
        end
        if (st_mv_y) begin
            n_cur_y = r_dir_y_neg ? r_cur_y - CB'(1) : r_cur_y + CB'(1);
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scr_w <= SCREEN_WIDTH_RST;
            r_scr_h <= SCREEN_HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SCREEN_WIDTH:  r_scr_w <= i_cfg_data;
                REG_SCREEN_HEIGHT: r_scr_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // line state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_goal_x    <= '0;
            r_goal_y    <= '0;
            r_dx        <= '0;
            r_dy        <= '0;
            r_dir_x_neg <= 1'b0;
            r_dir_y_neg <= 1'b0;
            r_err       <= '0;
            r_color     <= '0;
            r_widen     <= WIDEN_NONE;
        end else if (load_go) begin
            r_active    <= 1'b1;
            r_cur_x     <= in_x0;
            r_cur_y     <= in_y0;
            r_goal_x    <= in_x1;
            r_goal_y    <= in_y1;
            r_dx        <= ld_dx;
            r_dy        <= ld_dy;
            r_dir_x_neg <= !ld_gt_x;
            r_dir_y_neg <= !ld_gt_y;
            r_err       <= ld_err;
            r_color     <= in_color;
            r_widen     <= ld_widen;
        end else if (step_go) begin
            if (st_done) begin
                r_active <= 1'b0;
            end else begin
                r_cur_x <= n_cur_x;
                r_cur_y <= n_cur_y;
                r_err   <= n_err;
            end
        end
    end

    // pixel output register: holds the step's center pixel, walks the beats
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_beat   <= '0;
        end else if (step_go) begin
            r_ovalid <= 1'b1;
            r_beat   <= '0;
        end else if (out_fire) begin
            if (out_last) begin
                r_ovalid <= 1'b0;
            end else begin
                r_beat <= r_beat + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_go) begin
            r_ox     <= r_cur_x;
            r_oy     <= r_cur_y;
            r_ocolor <= r_color;
            r_owiden <= r_widen;
            r_odone  <= st_done;
        end
    end

    // pixel coordinates: center plus -1, 0, +1 across the widening axis
    logic signed [PIX_W-1:0] px_off, px_x, px_y;
    logic                    px_on;

    always_comb begin
        case (r_beat)
            2'd0:    px_off = (r_owiden == WIDEN_NONE) ? '0 : '1;
            2'd2:    px_off = PIX_W'(1);
            default: px_off = '0;
        endcase
        px_x = $signed({r_ox[CB-1], r_ox});
        px_y = $signed({r_oy[CB-1], r_oy});
        if (r_owiden == WIDEN_X) begin
            px_x = px_x + px_off;
        end
        if (r_owiden == WIDEN_Y) begin
            px_y = px_y + px_off;
        end
        px_on = !px_x[PIX_W-1] && !px_y[PIX_W-1]
                && (CMP_W'(px_x[PIX_W-2:0]) < CMP_W'(r_scr_w))
                && (CMP_W'(px_y[PIX_W-2:0]) < CMP_W'(r_scr_h));
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tlast  = out_last;
    assign m_axis_tuser  = {r_odone, px_on};
    assign m_axis_tdata  = OUT_DATA_W'({r_ocolor, px_y, px_x});

endmodule

>>> test/bls_checker.sv
// Scoreboard for the thick-line Bresenham stepper: watches the config port and both streams,
// predicts every emitted pixel and compares it field by field.
// Depends on bls_pkg.
module bls_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bls_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bls_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    input  logic [bls_pkg::IN_DATA_W-1:0]   i_s_tdata,
    input  logic                            i_s_tuser,
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    input  logic [bls_pkg::OUT_DATA_W-1:0]  i_m_tdata,
    input  logic [bls_pkg::OUT_USER_W-1:0]  i_m_tuser,
    input  logic                            i_m_tlast,
    output int                              o_mismatches,
    output int                              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import bls_pkg::*;

    localparam int COLOR_W = 4;

    typedef struct packed {
        logic [PIX_W-1:0]   x;
        logic [PIX_W-1:0]   y;
        logic [COLOR_W-1:0] color;
        logic               on_screen;
        logic               last;
        logic               done;
    } t_pixel;

    t_pixel pixel_q[$];
    int     errors = 0;

    // shadow of the stepper state and the screen size
    logic [CFG_W-1:0]              scr_w, scr_h;
    logic                          active;
    logic signed [COORD_BITS-1:0]  pos_x, pos_y, end_x, end_y;
    int                            span_x, span_y, err;
    logic                          x_neg, y_neg;
    logic [COLOR_W-1:0]            color;
    t_widen                        widen;

    // queue one pixel at (x, y) with its on-screen flag
    task automatic push_pixel(int x, int y, bit last, bit done);
        t_pixel p;
        p.x         = x[PIX_W-1:0];
        p.y         = y[PIX_W-1:0];
        p.color     = color;
        p.on_screen = (x >= 0) && (y >= 0) && (x < int'(scr_w)) && (y < int'(scr_h));
        p.last      = last;
        p.done      = done;
        pixel_q.push_back(p);
    endtask

    // latch endpoints and set up deltas, directions and the error term
    task automatic load_line(logic [IN_DATA_W-1:0] d);
        int x0, y0, x1, y1;
        x0 = $signed(d[0 +: COORD_BITS]);
        y0 = $signed(d[COORD_BITS +: COORD_BITS]);
        x1 = $signed(d[2*COORD_BITS +: COORD_BITS]);
        y1 = $signed(d[3*COORD_BITS +: COORD_BITS]);
        pos_x  = x0[COORD_BITS-1:0];
        pos_y  = y0[COORD_BITS-1:0];
        end_x  = x1[COORD_BITS-1:0];
        end_y  = y1[COORD_BITS-1:0];
        span_x = (x1 > x0) ? x1 - x0 : x0 - x1;
        span_y = (y1 > y0) ? y1 - y0 : y0 - y1;
        x_neg  = !(x0 < x1);
        y_neg  = !(y0 < y1);
        err    = (span_x > span_y) ? span_x / 2 : -(span_y / 2);
        color  = d[4*COORD_BITS +: COLOR_W];
        if (!d[4*COORD_BITS + COLOR_W])
            widen = WIDEN_NONE;
        else
            widen = (span_x >= span_y) ? WIDEN_Y : WIDEN_X;
        active = 1'b1;
    endtask

    // emit the current pixel(s), then advance one Bresenham step
    task automatic step_line();
        int cx, cy, e2;
        bit done;
        if (!active)
            return;
        cx   = pos_x;
        cy   = pos_y;
        done = (pos_x == end_x) && (pos_y == end_y);
        case (widen)
            WIDEN_Y: begin
                push_pixel(cx, cy - 1, 1'b0, done);
                push_pixel(cx, cy, 1'b0, done);
                push_pixel(cx, cy + 1, 1'b1, done);
            end
            WIDEN_X: begin
                push_pixel(cx - 1, cy, 1'b0, done);
                push_pixel(cx, cy, 1'b0, done);
                push_pixel(cx + 1, cy, 1'b1, done);
            end
            default: push_pixel(cx, cy, 1'b1, done);
        endcase
        if (done) begin
            active = 1'b0;
        end else begin
            e2 = err;
            if (e2 > -span_x) begin
                err   = err - span_y;
                pos_x = x_neg ? pos_x - 1'b1 : pos_x + 1'b1;
            end
            if (e2 < span_y) begin
                err   = err + span_x;
                pos_y = y_neg ? pos_y - 1'b1 : pos_y + 1'b1;
            end
        end
    endtask

    // compare one output beat against the oldest expected pixel
    task automatic check_pixel();
        t_pixel want, seen;
        seen.x         = i_m_tdata[0 +: PIX_W];
        seen.y         = i_m_tdata[PIX_W +: PIX_W];
        seen.color     = i_m_tdata[2*PIX_W +: COLOR_W];
        seen.on_screen = i_m_tuser[0];
        seen.done      = i_m_tuser[1];
        seen.last      = i_m_tlast;
        if (pixel_q.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected pixel beat: x=%0d y=%0d color=%0d on=%b last=%b done=%b",
                         $signed(seen.x), $signed(seen.y), seen.color, seen.on_screen,
                         seen.last, seen.done);
        end else begin
            want = pixel_q.pop_front();
            if (seen !== want) begin
                errors++;
                if (errors <= 10) begin
                    $display("pixel mismatch: exp x=%0d y=%0d color=%0d on=%b last=%b done=%b",
                             $signed(want.x), $signed(want.y), want.color, want.on_screen,
                             want.last, want.done);
                    $display("                got x=%0d y=%0d color=%0d on=%b last=%b done=%b",
                             $signed(seen.x), $signed(seen.y), seen.color, seen.on_screen,
                             seen.last, seen.done);
                end
            end
        end
    endtask

    // input beats are handled before output beats of the same edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            scr_w  = SCREEN_WIDTH_RST;
            scr_h  = SCREEN_HEIGHT_RST;
            active = 1'b0;
            widen  = WIDEN_NONE;
            color  = '0;
            pixel_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_SCREEN_WIDTH)
                    scr_w = i_cfg_data;
                else if (i_cfg_idx == REG_SCREEN_HEIGHT)
                    scr_h = i_cfg_data;
            end
            if (i_s_tvalid && i_s_tready) begin
                if (t_opcode'(i_s_tuser) == OP_LOAD)
                    load_line(i_s_tdata);
                else
                    step_line();
            end
            if (i_m_tvalid && i_m_tready)
                check_pixel();
        end
        o_pending    <= pixel_q.size();
        o_mismatches <= errors;
    end

endmodule

>>> test/tb.sv
// Testbench top for bresenham_line_stepper_thick_top: clock, reset, line stimulus and verdict.
// Pixel prediction and comparison live in bls_checker; depends on bls_pkg.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bls_pkg::*;

    localparam int CMIN = -(1 << (COORD_BITS - 1));
    localparam int CMAX = (1 << (COORD_BITS - 1)) - 1;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx     = '0;
    logic [CFG_W-1:0]       i_cfg_data    = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata  = '0;
    logic                   s_axis_tuser  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic [OUT_USER_W-1:0]  m_axis_tuser;
    logic                   m_axis_tlast;

    int mismatch_count;
    int pending_pixels;

    // idling percentages of the current phase
    int idle_pct  = 0;
    int stall_pct = 0;

    // screen size as last written, used to aim lines at the screen edges
    logic [CFG_W-1:0] scr_w = SCREEN_WIDTH_RST;
    logic [CFG_W-1:0] scr_h = SCREEN_HEIGHT_RST;

    bresenham_line_stepper_thick_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    bls_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .i_m_tlast    (m_axis_tlast),
        .o_mismatches (mismatch_count),
        .o_pending    (pending_pixels)
    );

    always #1 i_clk = ~i_clk;

    // pixel receiver with random back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // run limit
    initial begin
        #1_000_000;
        $display("[bresenham_line_stepper_thick_top] ERROR");
        $finish;
    end

    // tdata: x_start, y_start, x_end, y_end, pen_color, thick, zero pad
    function automatic logic [IN_DATA_W-1:0] pack_line(int x0, int y0, int x1, int y1,
                                                       int color, bit thick);
        logic [IN_DATA_W-1:0] p;
        p = '0;
        p[0 +: COORD_BITS]              = x0[COORD_BITS-1:0];
        p[COORD_BITS +: COORD_BITS]     = y0[COORD_BITS-1:0];
        p[2*COORD_BITS +: COORD_BITS]   = x1[COORD_BITS-1:0];
        p[3*COORD_BITS +: COORD_BITS]   = y1[COORD_BITS-1:0];
        p[4*COORD_BITS +: 4]            = color[3:0];
        p[4*COORD_BITS + 4]             = thick;
        return p;
    endfunction

    function automatic logic [IN_DATA_W-1:0] random_fields();
        return pack_line($urandom, $urandom, $urandom, $urandom, $urandom, 1'($urandom));
    endfunction

    function automatic int clamp_coord(int v);
        return (v < CMIN) ? CMIN : (v > CMAX) ? CMAX : v;
    endfunction

    // one input beat, with random idle cycles ahead of it
    task automatic send_beat(t_opcode op, logic [IN_DATA_W-1:0] payload);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= payload;
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // load a line and follow it with a number of step beats
    task automatic draw_line(int x0, int y0, int x1, int y1, int color, bit thick, int steps);
        send_beat(OP_LOAD, pack_line(x0, y0, x1, y1, color, thick));
        repeat (steps) send_beat(OP_STEP, random_fields());
    endtask

    // stop sending and wait until every expected pixel has come out
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_pixels != 0);
        repeat (8) @(posedge i_clk);
    endtask

    // both size registers, written back to back while the block is idle
    task automatic set_screen_size(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_SCREEN_WIDTH;
        i_cfg_data <= w;
        @(posedge i_clk);
        i_cfg_idx  <= REG_SCREEN_HEIGHT;
        i_cfg_data <= h;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        scr_w = w;
        scr_h = h;
    endtask

    // mostly short complete lines; some abandoned long ones and some noise
    task automatic random_lines(int beats);
        int sent, kind, reach, len, off, x0, y0, x1, y1;
        sent = 0;
        while (sent < beats) begin
            kind = $urandom_range(9);
            if (kind == 0) begin
                send_beat(t_opcode'($urandom_range(1)), random_fields());
                sent++;
            end else begin
                if (kind <= 4) begin
                    x0 = $urandom_range(4095);
                    x0 = x0 - 2048;
                    y0 = $urandom_range(4095);
                    y0 = y0 - 2048;
                end else begin
                    // start near the visible area so the on-screen flag toggles
                    x0 = $urandom_range(int'(scr_w) + 4);
                    x0 = x0 - 4;
                    y0 = $urandom_range(int'(scr_h) + 4);
                    y0 = y0 - 4;
                end
                reach = (kind == 1) ? 2047 : 6;
                off = $urandom_range(2 * reach);
                x1  = clamp_coord(x0 + off - reach);
                off = $urandom_range(2 * reach);
                y1  = clamp_coord(y0 + off - reach);
                len = (x1 > x0) ? x1 - x0 : x0 - x1;
                off = (y1 > y0) ? y1 - y0 : y0 - y1;
                len = ((len > off) ? len : off) + 1;
                if (kind == 1)
                    len = $urandom_range(6, 1);
                else if ($urandom_range(3) == 0)
                    len++;
                draw_line(x0, y0, x1, y1, $urandom_range(15), 1'($urandom_range(1)), len);
                sent += 1 + len;
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: idle step, zero-length line, extreme endpoints,
        // reload while active, both widening directions past the field range
        send_beat(OP_STEP, random_fields());
        draw_line(5, 5, 5, 5, 0, 1'b0, 2);
        draw_line(CMIN, CMAX, CMAX, CMIN, 15, 1'b1, 3);
        draw_line(0, 0, -3, 0, 10, 1'b1, 4);
        draw_line(CMAX, CMAX, CMAX - 1, CMAX - 3, 5, 1'b1, 4);
        draw_line(CMIN, CMIN, CMIN + 3, CMIN + 1, 3, 1'b1, 4);

        // random phases, each under its own screen size and idling mix
        for (int p = 0; p < 4; p++) begin
            drain_results();
            case (p)
                0: begin
                    idle_pct = 0;  stall_pct = 0;
                    set_screen_size(11'd2047, 11'd1);
                end
                1: begin
                    idle_pct = 72; stall_pct = 0;
                    set_screen_size(11'd1, 11'd2047);
                end
                2: begin
                    idle_pct = 0;  stall_pct = 72;
                    set_screen_size(11'd0, 11'd0);
                end
                default: begin
                    idle_pct = 20; stall_pct = 20;
                    set_screen_size(CFG_W'($urandom_range(2047, 1)),
                                    CFG_W'($urandom_range(2047, 1)));
                end
            endcase
            random_lines(76);
        end

        drain_results();
        if (mismatch_count == 0 && pending_pixels == 0)
            $display("[bresenham_line_stepper_thick_top] OK");
        else
            $display("[bresenham_line_stepper_thick_top] ERROR");
        $finish;
    end

endmodule
